[hdl/oicp_pkg.sv]
// Shared constants for the orientation and in-circle predicate pipeline.
package oicp_pkg;

    // Field layout on the stream ports.
    localparam int FIELD_W         = 16;
    localparam int NUM_IN_FIELDS   = 8;
    localparam int IN_TDATA_W      = ((NUM_IN_FIELDS * FIELD_W + 7) / 8) * 8;
    localparam int AREA_OUT_W      = 34;
    localparam int CCW_BIT         = AREA_OUT_W;
    localparam int INSIDE_BIT      = AREA_OUT_W + 1;
    localparam int OUT_BITS        = AREA_OUT_W + 2;
    localparam int OUT_TDATA_W     = ((OUT_BITS + 7) / 8) * 8;

    // Default number of coordinate bits actually used.
    localparam int COORD_WIDTH_DEF = 16;

    // Point indexes; the x coordinate of point k is field 2k, y is field 2k+1.
    localparam int NUM_PT = 4;
    localparam int PT_A   = 0;
    localparam int PT_B   = 1;
    localparam int PT_C   = 2;
    localparam int PT_D   = 3;

    // Triangle area indexes.
    localparam int NUM_AREA = 4;
    localparam int AREA_ABC = 0;
    localparam int AREA_BCD = 1;
    localparam int AREA_ACD = 2;
    localparam int AREA_ABD = 3;

endpackage

[hdl/oicp_front.sv]
// Front half of the pipeline: coordinate differences, squares, cross products, areas and norms.
module oicp_front #(
    parameter int COORD_WIDTH = oicp_pkg::COORD_WIDTH_DEF
) (
    input  logic                                               aclk,
    input  logic                                               aresetn,
    input  logic                                               in_valid,
    output logic                                               in_ready,
    input  logic [oicp_pkg::NUM_IN_FIELDS-1:0][COORD_WIDTH-1:0] in_coord,
    output logic                                               out_valid,
    input  logic                                               out_ready,
    output logic [oicp_pkg::NUM_AREA-1:0][2*COORD_WIDTH+1:0]    out_area,
    output logic [oicp_pkg::NUM_PT-1:0][2*COORD_WIDTH-1:0]      out_norm
);

    localparam int DW      = COORD_WIDTH + 1;
    localparam int PW      = 2 * COORD_WIDTH + 2;
    localparam int SW      = 2 * COORD_WIDTH;
    localparam int NDIFF   = 10;
    localparam int NPROD   = 2 * oicp_pkg::NUM_AREA;

    // Differences: b-a (x,y), c-a, d-a, c-b, d-b.
    localparam int DIFF_P [NDIFF] = '{2, 3, 4, 5, 6, 7, 4, 5, 6, 7};
    localparam int DIFF_Q [NDIFF] = '{0, 1, 0, 1, 0, 1, 2, 3, 2, 3};

    // Each area is prod[2k] - prod[2k+1], in the order abc, bcd, acd, abd.
    localparam int MUL_L [NPROD] = '{0, 1, 6, 7, 2, 3, 0, 1};
    localparam int MUL_R [NPROD] = '{3, 2, 9, 8, 5, 4, 5, 4};

    logic                                              vld1_reg, vld2_reg, vld3_reg;
    logic                                              rdy1, rdy2, rdy3;

    logic [NDIFF-1:0][DW-1:0]                          diff_next, diff1_reg;
    logic [oicp_pkg::NUM_IN_FIELDS-1:0][SW-1:0]        sq_next, sq1_reg;
    logic [NPROD-1:0][PW-1:0]                          prod_next, prod2_reg;
    logic [oicp_pkg::NUM_PT-1:0][SW-1:0]               norm_next, norm2_reg, norm3_reg;
    logic [oicp_pkg::NUM_AREA-1:0][PW-1:0]             area_next, area3_reg;

    assign rdy3     = !vld3_reg || out_ready;
    assign rdy2     = !vld2_reg || rdy3;
    assign rdy1     = !vld1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        logic signed [SW-1:0] ce;
        ce = '0;
        for (int i = 0; i < NDIFF; i++) begin
            diff_next[i] = DW'(signed'(in_coord[DIFF_P[i]]))
                         - DW'(signed'(in_coord[DIFF_Q[i]]));
        end
        for (int i = 0; i < oicp_pkg::NUM_IN_FIELDS; i++) begin
            ce         = SW'(signed'(in_coord[i]));
            sq_next[i] = ce * ce;
        end
    end

    always_comb begin
        for (int j = 0; j < NPROD; j++) begin
            prod_next[j] = PW'(signed'(diff1_reg[MUL_L[j]]))
                         * PW'(signed'(diff1_reg[MUL_R[j]]));
        end
        for (int k = 0; k < oicp_pkg::NUM_PT; k++) begin
            norm_next[k] = sq1_reg[2*k] + sq1_reg[2*k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < oicp_pkg::NUM_AREA; k++) begin
            area_next[k] = prod2_reg[2*k] - prod2_reg[2*k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else begin
            if (rdy1) vld1_reg <= in_valid;
            if (rdy2) vld2_reg <= vld1_reg;
            if (rdy3) vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            diff1_reg <= diff_next;
            sq1_reg   <= sq_next;
        end
        if (rdy2 && vld1_reg) begin
            prod2_reg <= prod_next;
            norm2_reg <= norm_next;
        end
        if (rdy3 && vld2_reg) begin
            area3_reg <= area_next;
            norm3_reg <= norm2_reg;
        end
    end

    assign out_valid = vld3_reg;
    assign out_area  = area3_reg;
    assign out_norm  = norm3_reg;

    a_accept_fills_stage1: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> vld1_reg)
        else $error("accepted word did not reach the first stage");

    a_stage3_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld3_reg && !out_ready) |=> (vld3_reg && $stable(area3_reg)))
        else $error("stalled area stage lost or changed its word");

endmodule

[hdl/oicp_det.sv]
// Back half of the pipeline: lifted terms, partial sums and the sign of the determinant.
module oicp_det #(
    parameter int COORD_WIDTH = oicp_pkg::COORD_WIDTH_DEF
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            in_valid,
    output logic                                            in_ready,
    input  logic [oicp_pkg::NUM_AREA-1:0][2*COORD_WIDTH+1:0] in_area,
    input  logic [oicp_pkg::NUM_PT-1:0][2*COORD_WIDTH-1:0]   in_norm,
    output logic                                            out_valid,
    input  logic                                            out_ready,
    output logic [2*COORD_WIDTH+1:0]                        out_area,
    output logic                                            out_inside
);

    localparam int AW   = 2 * COORD_WIDTH + 2;
    localparam int TW   = 4 * COORD_WIDTH + 3;
    localparam int SMW  = TW + 1;
    localparam int DETW = TW + 2;

    // Each point's norm is weighted by the area of the other three points.
    localparam int LIFT_AREA [oicp_pkg::NUM_PT] = '{oicp_pkg::AREA_BCD, oicp_pkg::AREA_ACD,
                                                   oicp_pkg::AREA_ABD, oicp_pkg::AREA_ABC};

    logic                                   vld4_reg, vld5_reg, vld6_reg;
    logic                                   rdy4, rdy5, rdy6;

    logic [oicp_pkg::NUM_PT-1:0][TW-1:0]    term_next, term4_reg;
    logic [SMW-1:0]                         sum0_next, sum1_next, sum0_5_reg, sum1_5_reg;
    logic                                   inside_next, inside6_reg;
    logic [AW-1:0]                          abc4_reg, abc5_reg, abc6_reg;

    assign rdy6     = !vld6_reg || out_ready;
    assign rdy5     = !vld5_reg || rdy6;
    assign rdy4     = !vld4_reg || rdy5;
    assign in_ready = rdy4;

    always_comb begin
        for (int k = 0; k < oicp_pkg::NUM_PT; k++) begin
            term_next[k] = TW'(signed'({1'b0, in_norm[k]}))
                         * TW'(signed'(in_area[LIFT_AREA[k]]));
        end
    end

    // Signs alternate: +a -b +c -d.
    assign sum0_next = SMW'(signed'(term4_reg[oicp_pkg::PT_A]))
                     - SMW'(signed'(term4_reg[oicp_pkg::PT_B]));
    assign sum1_next = SMW'(signed'(term4_reg[oicp_pkg::PT_C]))
                     - SMW'(signed'(term4_reg[oicp_pkg::PT_D]));

    always_comb begin
        logic [DETW-1:0] det;
        det         = DETW'(signed'(sum0_5_reg)) + DETW'(signed'(sum1_5_reg));
        inside_next = !det[DETW-1] && (det != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
        end else begin
            if (rdy4) vld4_reg <= in_valid;
            if (rdy5) vld5_reg <= vld4_reg;
            if (rdy6) vld6_reg <= vld5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && in_valid) begin
            term4_reg <= term_next;
            abc4_reg  <= in_area[oicp_pkg::AREA_ABC];
        end
        if (rdy5 && vld4_reg) begin
            sum0_5_reg <= sum0_next;
            sum1_5_reg <= sum1_next;
            abc5_reg   <= abc4_reg;
        end
        if (rdy6 && vld5_reg) begin
            inside6_reg <= inside_next;
            abc6_reg    <= abc5_reg;
        end
    end

    assign out_valid  = vld6_reg;
    assign out_area   = abc6_reg;
    assign out_inside = inside6_reg;

    a_term_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld4_reg && !rdy4) |=> (vld4_reg && $stable(term4_reg)))
        else $error("stalled term stage lost or changed its word");

    a_sign_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld6_reg && !out_ready) |=> (vld6_reg && $stable(inside6_reg) && $stable(abc6_reg)))
        else $error("stalled sign stage lost or changed its word");

endmodule

[hdl/orientation_incircle_predicate.sv]
// Top level of the orientation and in-circle predicate pipeline with its output register.
//
// Each input word carries four points a, b, c and d; each result word carries twice the
// signed area of triangle a, b, c, a counterclockwise flag, and a flag that is set when the
// lifted in-circle determinant is positive, meaning d lies strictly inside the circle through
// a, b and c when they run counterclockwise (clockwise order inverts that flag, and
// cocircular or collinear cases follow the exact sign of the determinant). All arithmetic is
// exact integer arithmetic, so nothing is rounded. The block accepts one word per clock while
// m_tready does not stall it and delivers exactly one result word per input word, in order.
// A result passes through six pipeline stages plus the output register before it appears on
// m_tvalid. The stage depth is set by the multipliers: the coordinate squares and the 17-bit
// cross products, then the 33-by-34-bit lifted terms, each followed by a register, then two
// adder levels for the 69-bit determinant. Every stage carries its own valid bit and
// is ready whenever it is empty or its successor is ready, so new words keep entering while a
// finished result waits on m_tready until every stage is full, and a stall neither drops nor
// repeats any word. Only the low COORD_WIDTH bits of each input field are used, taken as two's
// complement. Reset clears the valid bits only; there are no configuration registers.
module orientation_incircle_predicate #(
    parameter int COORD_WIDTH = oicp_pkg::COORD_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0 up: pa_x, pa_y, pb_x, pb_y, pc_x, pc_y, pd_x, pd_y (16 bits each).
    input  logic [oicp_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0 up: twice_area (34 bits), is_ccw, d_inside, then four zero bits.
    output logic [oicp_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int AW = 2 * COORD_WIDTH + 2;

    logic [oicp_pkg::NUM_IN_FIELDS-1:0][COORD_WIDTH-1:0] coord;

    logic                                       fr_valid, fr_ready;
    logic [oicp_pkg::NUM_AREA-1:0][AW-1:0]      fr_area;
    logic [oicp_pkg::NUM_PT-1:0][2*COORD_WIDTH-1:0] fr_norm;

    logic                                       det_valid, det_ready;
    logic [AW-1:0]                              det_area;
    logic                                       det_inside;

    logic                                       out_vld_reg;
    logic [oicp_pkg::OUT_TDATA_W-1:0]           out_data_reg, out_data_next;

    // Only the low COORD_WIDTH bits of every field take part.
    always_comb begin
        for (int i = 0; i < oicp_pkg::NUM_IN_FIELDS; i++) begin
            coord[i] = s_tdata[i*oicp_pkg::FIELD_W +: COORD_WIDTH];
        end
    end

    oicp_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_coord  (coord),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_area  (fr_area),
        .out_norm  (fr_norm)
    );

    oicp_det #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_det (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (fr_valid),
        .in_ready   (fr_ready),
        .in_area    (fr_area),
        .in_norm    (fr_norm),
        .out_valid  (det_valid),
        .out_ready  (det_ready),
        .out_area   (det_area),
        .out_inside (det_inside)
    );

    // The output register takes a new word whenever it is empty or being drained.
    assign det_ready = !out_vld_reg || m_tready;

    always_comb begin
        out_data_next                                  = '0;
        out_data_next[oicp_pkg::AREA_OUT_W-1:0]        = oicp_pkg::AREA_OUT_W'(signed'(det_area));
        out_data_next[oicp_pkg::CCW_BIT]               = !det_area[AW-1] && (det_area != '0);
        out_data_next[oicp_pkg::INSIDE_BIT]            = det_inside;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (det_ready) begin
            out_vld_reg <= det_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (det_ready && det_valid) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // With the output register empty, every stage before it can move, so input is open.
    a_empty_out_opens_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_vld_reg |-> s_tready)
        else $error("input blocked although the output register is empty");

    a_ccw_only_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[oicp_pkg::CCW_BIT])
            |-> (m_tdata[oicp_pkg::AREA_OUT_W-1:0] != '0))
        else $error("counterclockwise flag set for a collinear triangle");

endmodule
